FILE: hdl/nee_pkg.sv
package nee_pkg;

    localparam int PROB_W  = 16;
    localparam int LOW_W   = 7;
    localparam int PITCH_W = 8;
    localparam int OUT_W   = 20;
    localparam int CIDX_W  = 8;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [OUT_W-1:0] INDEX_MAX = {OUT_W{1'b1}};

    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_LOWEST    = 8'd1;

    localparam logic [PROB_W-1:0] THRESHOLD_RST = 16'd32768;
    localparam logic [LOW_W-1:0]  LOWEST_RST    = 7'd21;

    typedef struct packed {
        logic [PROB_W-1:0] onset_prob;
        logic [PROB_W-1:0] frame_prob;
    } t_nee_cell;

    typedef struct packed {
        logic [PITCH_W-1:0] note_pitch;
        logic [OUT_W-1:0]   start_frame;
        logic [OUT_W-1:0]   duration_frames;
    } t_nee_note;

    typedef struct packed {
        logic [PITCH_W-1:0] note_pitch;
        logic [OUT_W-1:0]   start_frame;
        logic [OUT_W-1:0]   duration_frames;
        logic [OUT_W-1:0]   note_index;
    } t_nee_result;

    typedef struct packed {
        logic               push;
        t_nee_note          data;
    } t_nee_push;

endpackage

FILE: hdl/nee_ram.sv
module nee_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 88
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/nee_front.sv
module nee_front #(
    parameter int PITCH_ROWS = 88,
    parameter int FRAME_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  nee_pkg::t_nee_cell                i_in_data,
    input  logic [nee_pkg::PROB_W-1:0]        i_threshold,
    input  logic [nee_pkg::LOW_W-1:0]         i_lowest_pitch,
    input  logic [nee_pkg::QCNT_W-1:0]        i_q_level,
    output nee_pkg::t_nee_push                o_push
);

    localparam int ROW_W   = (PITCH_ROWS > 1) ? $clog2(PITCH_ROWS) : 1;
    localparam int OUT_W   = nee_pkg::OUT_W;
    localparam int PITCH_W = nee_pkg::PITCH_W;
    localparam int QCNT_W  = nee_pkg::QCNT_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(PITCH_ROWS - 1);

    logic [ROW_W-1:0]      r_row;
    logic [FRAME_BITS-1:0] r_frame;
    logic [PITCH_ROWS-1:0] r_in_note;
    logic [PITCH_ROWS-1:0] r_last_onset;
    logic                  r_s1_valid;
    logic [ROW_W-1:0]      r_s1_row;
    logic [FRAME_BITS-1:0] r_s1_frame;

    logic                  w_accept;
    logic                  w_on;
    logic                  w_fr;
    logic                  w_active;
    logic                  w_cur_in;
    logic                  w_cur_last;
    logic                  w_emit;
    logic                  w_write_start;
    logic [FRAME_BITS-1:0] w_start;
    logic [FRAME_BITS-1:0] w_dur;
    logic [FRAME_BITS+OUT_W-1:0] w_start_ext;
    logic [FRAME_BITS+OUT_W-1:0] w_dur_ext;
    logic [QCNT_W:0]       w_pending;

    assign w_pending  = {1'b0, i_q_level} + {{QCNT_W{1'b0}}, r_s1_valid};
    assign o_in_ready = (w_pending < (QCNT_W + 1)'(nee_pkg::QDEPTH));
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_on          = i_in_data.onset_prob > i_threshold;
    assign w_fr          = i_in_data.frame_prob > i_threshold;
    assign w_active      = w_on && w_fr;
    assign w_cur_in      = r_in_note[r_row];
    assign w_cur_last    = r_last_onset[r_row];
    assign w_emit        = w_active ? (w_cur_in && !w_cur_last) : w_cur_in;
    assign w_write_start = w_active && (!w_cur_in || !w_cur_last);

    nee_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (PITCH_ROWS)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_write_start),
        .i_waddr (r_row),
        .i_wdata (r_frame),
        .i_raddr (r_row),
        .o_rdata (w_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_frame      <= '0;
            r_in_note    <= '0;
            r_last_onset <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_s1_valid <= w_accept && w_emit;
            if (w_accept) begin
                r_in_note[r_row]    <= w_active;
                r_last_onset[r_row] <= w_on;
                if (r_row == LAST_ROW) begin
                    r_row   <= '0;
                    r_frame <= r_frame + 1'b1;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_row   <= r_row;
            r_s1_frame <= r_frame;
        end
    end

    // duration wraps with the frame counter
    assign w_dur       = r_s1_frame - w_start;
    assign w_start_ext = {{OUT_W{1'b0}}, w_start};
    assign w_dur_ext   = {{OUT_W{1'b0}}, w_dur};

    always_comb begin
        o_push.push                 = r_s1_valid;
        o_push.data.note_pitch      = PITCH_W'(r_s1_row) + PITCH_W'(i_lowest_pitch);
        o_push.data.start_frame     = w_start_ext[OUT_W-1:0];
        o_push.data.duration_frames = w_dur_ext[OUT_W-1:0];
    end

    a_s1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(w_accept))
        else $error("note issued without an accepted cell");

endmodule

FILE: hdl/nee_fifo.sv
module nee_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nee_pkg::t_nee_push         i_push,
    input  logic                       i_pop,
    output logic                       o_empty,
    output nee_pkg::t_nee_note         o_data,
    output logic [nee_pkg::QCNT_W-1:0] o_level
);

    localparam int QPTR_W = nee_pkg::QPTR_W;
    localparam int QCNT_W = nee_pkg::QCNT_W;

    nee_pkg::t_nee_note r_mem [nee_pkg::QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push.push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign o_level = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> (r_count != QCNT_W'(nee_pkg::QDEPTH)) || i_pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue underflow");

endmodule

FILE: hdl/nee_back.sv
module nee_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  nee_pkg::t_nee_note   i_q_data,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output nee_pkg::t_nee_result o_out_data
);

    localparam int OUT_W = nee_pkg::OUT_W;

    logic                 r_valid;
    logic [OUT_W-1:0]     r_count;
    nee_pkg::t_nee_result r_data;

    assign o_pop = !i_q_empty && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (r_count != nee_pkg::INDEX_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data.note_pitch      <= i_q_data.note_pitch;
            r_data.start_frame     <= i_q_data.start_frame;
            r_data.duration_frames <= i_q_data.duration_frames;
            r_data.note_index      <= r_count;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_pop) && ($past(r_count) != nee_pkg::INDEX_MAX)
            |-> r_count == $past(r_count) + 1'b1)
        else $error("note index did not advance");

endmodule

FILE: hdl/note_event_extractor.sv
// channel  direction  signals                                        payload
// in       input      i_in_valid / o_in_ready                        i_in_data (cell)
// out      output     o_out_valid / i_out_ready                      o_out_data (note)
// cfg      input      i_cfg_valid / o_cfg_ready                      i_cfg_index, i_cfg_data
//
// one cell per cycle while o_in_ready is high; a closed note reaches o_out_valid
// after its cell passes the start frame ram read, four-entry queue and output register
// synchronous active-low reset clears flags and counters and loads config defaults; no clearing pass
// in_ready drops only when the note queue plus the ram read stage hold four notes
// cfg_ready is always high
module note_event_extractor #(
    parameter int PITCH_ROWS = 88,
    parameter int FRAME_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nee_pkg::t_nee_cell            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nee_pkg::t_nee_result          o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nee_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [nee_pkg::PROB_W-1:0]    i_cfg_data
);

    localparam int LOW_W = nee_pkg::LOW_W;

    logic [nee_pkg::PROB_W-1:0] r_threshold;
    logic [LOW_W-1:0]           r_lowest_pitch;

    nee_pkg::t_nee_push         w_push;
    nee_pkg::t_nee_note         w_q_data;
    logic [nee_pkg::QCNT_W-1:0] w_q_level;
    logic                       w_q_empty;
    logic                       w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= nee_pkg::THRESHOLD_RST;
            r_lowest_pitch <= nee_pkg::LOWEST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nee_pkg::CFG_THRESHOLD: r_threshold    <= i_cfg_data;
                nee_pkg::CFG_LOWEST:    r_lowest_pitch <= i_cfg_data[LOW_W-1:0];
                default: ;
            endcase
        end
    end

    nee_front #(
        .PITCH_ROWS (PITCH_ROWS),
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_threshold    (r_threshold),
        .i_lowest_pitch (r_lowest_pitch),
        .i_q_level      (w_q_level),
        .o_push         (w_push)
    );

    nee_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_data),
        .o_level (w_q_level)
    );

    nee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sim/tb_note_event_extractor.sv
`timescale 1ns / 1ps

module tb_note_event_extractor;

    localparam int ROWS    = 88;
    localparam int FBITS   = 20;
    localparam int LIMIT   = 400000;
    localparam int SETTLE  = 8;
    localparam int PROB_W  = nee_pkg::PROB_W;
    localparam int LOW_W   = nee_pkg::LOW_W;
    localparam int CIDX_W  = nee_pkg::CIDX_W;
    localparam int OUT_W   = nee_pkg::OUT_W;
    localparam int PITCH_W = nee_pkg::PITCH_W;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    nee_pkg::t_nee_cell    i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    nee_pkg::t_nee_result  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CIDX_W-1:0]     i_cfg_index = '0;
    logic [PROB_W-1:0]     i_cfg_data = '0;

    note_event_extractor #(
        .PITCH_ROWS(ROWS),
        .FRAME_BITS(FBITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    class note_predictor;
        bit [PROB_W-1:0]      threshold;
        bit [LOW_W-1:0]       lowest;
        bit                   in_note [ROWS];
        bit [FBITS-1:0]       note_start [ROWS];
        bit                   last_onset [ROWS];
        int unsigned          row;
        bit [FBITS-1:0]       frame_count;
        bit [OUT_W-1:0]       notes_emitted;
        nee_pkg::t_nee_result pending_notes [$];
        int unsigned          mismatches;
        int unsigned          notes_checked;

        function new();
            threshold = nee_pkg::THRESHOLD_RST;
            lowest    = nee_pkg::LOWEST_RST;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [PROB_W-1:0] data);
            case (idx)
                nee_pkg::CFG_THRESHOLD: threshold = data;
                nee_pkg::CFG_LOWEST:    lowest = data[LOW_W-1:0];
                default: ;
            endcase
        endfunction

        function void close_note(int unsigned r);
            nee_pkg::t_nee_result n;
            bit [FBITS-1:0]       span;
            span              = frame_count - note_start[r];
            n.note_pitch      = PITCH_W'(r) + PITCH_W'(lowest);
            n.start_frame     = OUT_W'(note_start[r]);
            n.duration_frames = OUT_W'(span);
            n.note_index      = notes_emitted;
            if (notes_emitted != nee_pkg::INDEX_MAX) begin
                notes_emitted++;
            end
            pending_notes.push_back(n);
        endfunction

        // one accepted cell transaction
        function void take_cell(nee_pkg::t_nee_cell c);
            bit onset_hit;
            bit frame_hit;
            onset_hit = c.onset_prob > threshold;
            frame_hit = c.frame_prob > threshold;
            if (onset_hit && frame_hit) begin
                if (!in_note[row]) begin
                    in_note[row]    = 1'b1;
                    note_start[row] = frame_count;
                end else if (!last_onset[row]) begin
                    close_note(row);
                    note_start[row] = frame_count;
                end
            end else if (in_note[row]) begin
                close_note(row);
                in_note[row] = 1'b0;
            end
            last_onset[row] = onset_hit;
            if (row == ROWS - 1) begin
                row = 0;
                frame_count++;
            end else begin
                row++;
            end
        endfunction

        function void check_note(nee_pkg::t_nee_result got);
            nee_pkg::t_nee_result want;
            if (pending_notes.size() == 0) begin
                $display("%0t: unexpected note, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_notes.pop_front();
            notes_checked++;
            if (got.note_pitch !== want.note_pitch) begin
                $display("%0t: note_pitch expected %0d actual %0d",
                         $time, want.note_pitch, got.note_pitch);
                mismatches++;
            end
            if (got.start_frame !== want.start_frame) begin
                $display("%0t: start_frame expected %0d actual %0d",
                         $time, want.start_frame, got.start_frame);
                mismatches++;
            end
            if (got.duration_frames !== want.duration_frames) begin
                $display("%0t: duration_frames expected %0d actual %0d",
                         $time, want.duration_frames, got.duration_frames);
                mismatches++;
            end
            if (got.note_index !== want.note_index) begin
                $display("%0t: note_index expected %0d actual %0d",
                         $time, want.note_index, got.note_index);
                mismatches++;
            end
        endfunction
    endclass

    note_predictor pred = new();

    bit          row_busy [ROWS];
    bit          steady;
    int          out_hold;
    int          out_gap;
    int unsigned cycles;
    int unsigned cells_sent;
    int unsigned reg_writes;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        if (steady || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PROB_W-1:0] level(bit hit, logic [PROB_W-1:0] thr);
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (hit && thr != '1) begin
            if (pick == 0) return thr + 1'b1;
            if (pick == 1) return '1;
            return PROB_W'($urandom_range(int'(thr) + 1, 16'hFFFF));
        end
        if (pick == 0) return thr;
        if (pick == 1) return '0;
        return PROB_W'($urandom_range(0, int'(thr)));
    endfunction

    // sustained notes per row, with some plain noise cells
    function automatic nee_pkg::t_nee_cell next_cell();
        nee_pkg::t_nee_cell c;
        int unsigned        r;
        int unsigned        mode;
        r = pred.row;
        if ($urandom_range(0, 99) < 8) begin
            c.onset_prob = PROB_W'($urandom);
            c.frame_prob = PROB_W'($urandom);
            return c;
        end
        if (row_busy[r]) begin
            row_busy[r] = $urandom_range(0, 9) < 7;
        end else begin
            row_busy[r] = $urandom_range(0, 9) < 3;
        end
        if (row_busy[r]) begin
            c.onset_prob = level(1'b1, pred.threshold);
            c.frame_prob = level(1'b1, pred.threshold);
        end else begin
            mode = $urandom_range(0, 2);
            c.onset_prob = level(mode == 0, pred.threshold);
            c.frame_prob = level(mode == 1, pred.threshold);
        end
        return c;
    endfunction

    task automatic send_cell(nee_pkg::t_nee_cell c, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        pred.take_cell(c);
        cells_sent++;
    endtask

    task automatic run_cells(int n);
        steady = $urandom_range(0, 3) == 0;
        repeat (n) send_cell(next_cell(), pick_gap());
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pred.pending_notes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [PROB_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        pred.write_reg(idx, data);
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pred.check_note(o_out_data);
        end
        if (out_hold > 0) begin
            out_hold    <= out_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            out_gap = pick_gap();
            if (out_gap == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                out_hold    <= out_gap - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0]       opening [14];
        logic [CIDX_W-1:0] stray_idx;

        opening = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_8000, 32'h8001_8001,
            32'h8001_8000, 32'h8000_8001, 32'hFFFF_0000, 32'h0000_FFFF,
            32'h8001_FFFF, 32'hFFFF_8001, 32'h0001_7FFF, 32'hAAAA_5555,
            32'h5555_AAAA, 32'hC000_C000
        };
        steady = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds, first frame onsets
        foreach (opening[k]) begin
            send_cell(nee_pkg::t_nee_cell'(opening[k]), 0);
        end
        run_cells(200);

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(nee_pkg::CFG_THRESHOLD, '0);
                    write_reg(nee_pkg::CFG_LOWEST, 16'h007F);
                end
                1: begin
                    write_reg(nee_pkg::CFG_THRESHOLD, '1);
                    write_reg(nee_pkg::CFG_LOWEST, '0);
                end
                2: begin
                    stray_idx = CIDX_W'($urandom_range(int'(nee_pkg::CFG_LOWEST) + 1,
                                                       (1 << CIDX_W) - 1));
                    write_reg(stray_idx, PROB_W'($urandom));
                    write_reg(nee_pkg::CFG_THRESHOLD, 16'd1);
                    write_reg(nee_pkg::CFG_LOWEST,
                              16'hFF80 | PROB_W'($urandom_range(0, 127)));
                end
                3: begin
                    write_reg(nee_pkg::CFG_THRESHOLD, 16'hFFFE);
                end
                default: begin
                    write_reg(nee_pkg::CFG_THRESHOLD, PROB_W'($urandom));
                    write_reg(nee_pkg::CFG_LOWEST, PROB_W'($urandom));
                end
            endcase
            run_cells(phase == 1 ? 100 : 150);
        end

        // zero frame closes whatever is still open
        steady = 1'b0;
        repeat (ROWS) send_cell('0, pick_gap());
        settle();

        $display("run covered %0d cells and %0d notes across %0d register writes",
                 cells_sent, pred.notes_checked, reg_writes);
        if (pred.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", pred.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
